@@ sv/tccb_pkg.sv @@
package tccb_pkg;

  // fixed field widths
  localparam int unsigned CODE_W = 8;
  localparam int unsigned ADDR_W = 11;
  localparam int unsigned DATA_W = 7;
  localparam int unsigned CURS_W = 11;

  // command codes
  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // character codes
  localparam logic [CODE_W-1:0] CODE_BS = 8'h08;
  localparam logic [CODE_W-1:0] CODE_NL = 8'h0A;
  localparam logic [CODE_W-1:0] CODE_LO = 8'h20;
  localparam logic [CODE_W-1:0] CODE_HI = 8'h7E;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_RD_WAIT,
    ST_SCROLL,
    ST_ROW_CLR,
    ST_FINISH
  } tccb_state_t;

endpackage

@@ sv/tccb_in_if.sv @@
interface tccb_in_if;
  import tccb_pkg::*;

  logic              valid;
  logic              ready;
  logic              command;
  logic [CODE_W-1:0] char_code;
  logic [ADDR_W-1:0] read_address;

  modport source (output valid, output command, output char_code, output read_address,
                  input ready);
  modport sink (input valid, input command, input char_code, input read_address,
                output ready);
endinterface

@@ sv/tccb_out_if.sv @@
interface tccb_out_if;
  import tccb_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic [CURS_W-1:0] cursor_position;
  logic              scrolled;

  modport source (output valid, output read_data, output cursor_position, output scrolled,
                  input ready);
  modport sink (input valid, input read_data, input cursor_position, input scrolled,
                output ready);
endinterface

@@ sv/text_console_cell_buffer.sv @@
// character-cell console store, ROWS x COLS cells of 7 bits, one linear cursor
// in_ch  : items with command (put / read), char_code and read_address
// out_ch : one result item per input item: read_data, cursor_position, scrolled
// a put item stores a printable code or newline at the cursor, handles backspace,
// and scrolls the whole store up one row when the cursor runs off the end
// a put of a plain character passes through ST_EXEC and ST_FINISH before its result
// item is valid, an in-range read through ST_EXEC, ST_RD_WAIT (registered ram read)
// and ST_FINISH; a new item is taken only after the previous one is finished
// a backspace that leaves its row adds a row clear in ST_ROW_CLR; a scroll adds
// the move in ST_SCROLL plus clearing the last row in ST_ROW_CLR, all set by the
// single write port of the cell ram (one cell per cycle)
// one item is in work at a time; the next item is taken once the previous one
// has been handed to the output register, so a stalled receiver holds one
// finished item and the block stalls behind it only when a second one is done
// reset: cursor to zero, then a clearing pass in ST_CLEAR zeroes every cell of the
// ram, during which in_ch.ready stays low
module text_console_cell_buffer #(
  parameter int unsigned COLS = 80,
  parameter int unsigned ROWS = 25
) (
  input  logic clk,
  input  logic rst_n,
  tccb_in_if.sink    in_ch,
  tccb_out_if.source out_ch
);
  import tccb_pkg::*;

  localparam int unsigned CELLS = ROWS * COLS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned CW    = $clog2(COLS);
  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned CTW   = $clog2(CELLS + 1);
  localparam int unsigned XW    = (AW > ADDR_W) ? AW : ADDR_W;

  localparam logic [CTW-1:0] CNT_CELLS   = CTW'(CELLS);
  localparam logic [CTW-1:0] CNT_LAST    = CTW'(CELLS - 1);
  localparam logic [CTW-1:0] CNT_COLS    = CTW'(COLS);
  localparam logic [CTW-1:0] CNT_COLS_M1 = CTW'(COLS - 1);
  localparam logic [CTW-1:0] CNT_COLS_P1 = CTW'(COLS + 1);
  localparam logic [AW-1:0]  LIN_LAST    = AW'(CELLS - 1);
  localparam logic [AW-1:0]  LAST_BASE   = AW'((ROWS - 1) * COLS);
  localparam logic [CW-1:0]  COL_LAST    = CW'(COLS - 1);
  localparam logic [RW-1:0]  ROW_LAST    = RW'(ROWS - 1);
  localparam logic [31:0]    CELLS_32    = 32'(CELLS);

  tccb_state_t state_r, state_nxt;

  // latched item
  logic              cmd_r, cmd_nxt;
  logic [CODE_W-1:0] char_r, char_nxt;
  logic [ADDR_W-1:0] raddr_r, raddr_nxt;

  // cursor kept as row, column and linear index
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [AW-1:0] lin_r, lin_nxt;

  // sweep counter shared by clearing pass, scroll move and row clear
  logic [CTW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0]  base_r, base_nxt;
  logic           pend_r, pend_nxt;

  // per-item result
  logic [DATA_W-1:0] data_r, data_nxt;
  logic              scr_r, scr_nxt;

  // output register
  logic              ovalid_r, ovalid_nxt;
  logic [DATA_W-1:0] odata_r, odata_nxt;
  logic [CURS_W-1:0] ocur_r, ocur_nxt;
  logic              oscr_r, oscr_nxt;

  // ram port
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic [XW-1:0]    raddr_ext;
  logic [XW-1:0]    lin_ext;
  logic [CTW-1:0]   scr_wr_cnt;
  logic [AW:0]      lin_nl;
  logic             in_acc;
  logic             out_free;

  assign raddr_ext  = XW'(raddr_r);
  assign lin_ext    = XW'(lin_r);
  assign scr_wr_cnt = cnt_r - CNT_COLS_P1;
  assign lin_nl     = (AW + 1)'(lin_r) + (AW + 1)'(COLS) - (AW + 1)'(col_r);

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && (state_r == ST_IDLE);
  assign out_free    = !ovalid_r || out_ch.ready;

  assign out_ch.valid           = ovalid_r;
  assign out_ch.read_data       = odata_r;
  assign out_ch.cursor_position = ocur_r;
  assign out_ch.scrolled        = oscr_r;

  tccb_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      row_r    <= '0;
      col_r    <= '0;
      lin_r    <= '0;
      cnt_r    <= '0;
      pend_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      lin_r    <= lin_nxt;
      cnt_r    <= cnt_nxt;
      pend_r   <= pend_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    char_r  <= char_nxt;
    raddr_r <= raddr_nxt;
    base_r  <= base_nxt;
    data_r  <= data_nxt;
    scr_r   <= scr_nxt;
    odata_r <= odata_nxt;
    ocur_r  <= ocur_nxt;
    oscr_r  <= oscr_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    char_nxt   = char_r;
    raddr_nxt  = raddr_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    lin_nxt    = lin_r;
    cnt_nxt    = cnt_r;
    base_nxt   = base_r;
    pend_nxt   = pend_r;
    data_nxt   = data_r;
    scr_nxt    = scr_r;
    ovalid_nxt = ovalid_r && !out_ch.ready;
    odata_nxt  = odata_r;
    ocur_nxt   = ocur_r;
    oscr_nxt   = oscr_r;
    ram_we     = 1'b0;
    ram_waddr  = lin_r;
    ram_wdata  = '0;
    ram_raddr  = raddr_ext[AW-1:0];

    case (state_r)
      // zero every cell after reset
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r[AW-1:0];
        if (cnt_r == CNT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      ST_IDLE: begin
        if (in_acc) begin
          cmd_nxt   = in_ch.command;
          char_nxt  = in_ch.char_code;
          raddr_nxt = in_ch.read_address;
          data_nxt  = '0;
          scr_nxt   = 1'b0;
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        state_nxt = ST_FINISH;
        if (cmd_r == CMD_READ) begin
          // out-of-range reads return zero without a ram access
          if (32'(raddr_r) < CELLS_32) begin
            state_nxt = ST_RD_WAIT;
          end
        end else begin
          case (char_r)
            CODE_BS: begin
              if (lin_r != '0) begin
                ram_we    = 1'b1;
                ram_waddr = lin_r - 1'b1;
                lin_nxt   = lin_r - 1'b1;
                if (col_r == '0) begin
                  // stepped back onto the previous row: wipe the row we left
                  col_nxt   = COL_LAST;
                  row_nxt   = row_r - 1'b1;
                  base_nxt  = lin_r;
                  cnt_nxt   = '0;
                  state_nxt = ST_ROW_CLR;
                end else begin
                  col_nxt = col_r - 1'b1;
                end
              end
            end
            CODE_NL: begin
              ram_we    = 1'b1;
              ram_wdata = DATA_W'(CODE_NL);
              if (row_r == ROW_LAST) begin
                cnt_nxt   = CNT_COLS;
                pend_nxt  = 1'b0;
                state_nxt = ST_SCROLL;
              end else begin
                row_nxt = row_r + 1'b1;
                col_nxt = '0;
                lin_nxt = lin_nl[AW-1:0];
              end
            end
            default: begin
              if (char_r inside {[CODE_LO:CODE_HI]}) begin
                ram_we    = 1'b1;
                ram_wdata = char_r[DATA_W-1:0];
                if (lin_r == LIN_LAST) begin
                  cnt_nxt   = CNT_COLS;
                  pend_nxt  = 1'b0;
                  state_nxt = ST_SCROLL;
                end else begin
                  lin_nxt = lin_r + 1'b1;
                  if (col_r == COL_LAST) begin
                    col_nxt = '0;
                    row_nxt = row_r + 1'b1;
                  end else begin
                    col_nxt = col_r + 1'b1;
                  end
                end
              end
            end
          endcase
        end
      end

      ST_RD_WAIT: begin
        data_nxt  = ram_rdata;
        state_nxt = ST_FINISH;
      end

      // move every cell up one row: read cell n, write it to n-COLS next cycle
      ST_SCROLL: begin
        ram_raddr = cnt_r[AW-1:0];
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = scr_wr_cnt[AW-1:0];
          ram_wdata = ram_rdata;
        end
        if (cnt_r < CNT_CELLS) begin
          cnt_nxt  = cnt_r + 1'b1;
          pend_nxt = 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          cnt_nxt   = '0;
          base_nxt  = LAST_BASE;
          row_nxt   = ROW_LAST;
          col_nxt   = '0;
          lin_nxt   = LAST_BASE;
          scr_nxt   = 1'b1;
          state_nxt = ST_ROW_CLR;
        end
      end

      ST_ROW_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = base_r + cnt_r[AW-1:0];
        if (cnt_r == CNT_COLS_M1) begin
          cnt_nxt   = '0;
          state_nxt = ST_FINISH;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      // hand the result to the output register once it is free
      ST_FINISH: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = data_r;
          ocur_nxt   = lin_ext[CURS_W-1:0];
          oscr_nxt   = scr_r;
          state_nxt  = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end
endmodule

@@ sv/tccb_ram.sv @@
module tccb_ram #(
  parameter int unsigned WIDTH = 7,
  parameter int unsigned DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ bench/cell_buffer_monitor.sv @@
`timescale 1ns / 1ps
module cell_buffer_monitor #(
  parameter int unsigned COLS = 80,
  parameter int unsigned ROWS = 25
) (
  input  logic clk,
  input  logic rst_n,
  tccb_in_if   in_tap,
  tccb_out_if  out_tap,
  output int   fail_count,
  output int   backlog
);
  import tccb_pkg::*;

  localparam int unsigned CELLS = COLS * ROWS;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [CURS_W-1:0] cursor_position;
    logic              scrolled;
  } cell_result_t;

  logic [DATA_W-1:0] cells [CELLS];
  int unsigned       cursor;
  cell_result_t      awaited_results [$];
  int unsigned       result_count;

  function automatic void wipe_row(int unsigned row);
    for (int unsigned c = 0; c < COLS; c++) cells[row * COLS + c] = '0;
  endfunction

  // one console step: updates the shadow store and cursor, returns the result item
  function automatic cell_result_t console_apply(logic cmd, logic [CODE_W-1:0] code,
                                                 logic [ADDR_W-1:0] addr);
    cell_result_t r;
    int unsigned  spot;
    int unsigned  row0;
    r = '0;
    if (cursor >= CELLS) cursor = 0;
    if (cmd == CMD_READ) begin
      if (addr < CELLS) r.read_data = cells[addr];
    end else begin
      spot = cursor;
      if (code == CODE_BS) begin
        if (spot > 0) begin
          row0 = spot / COLS;
          spot--;
          cells[spot] = '0;
          if (spot / COLS < row0) wipe_row(row0);
        end
      end else if (code == CODE_NL) begin
        cells[spot] = CODE_NL[DATA_W-1:0];
        spot = (spot / COLS + 1) * COLS;
      end else if (code >= CODE_LO && code <= CODE_HI) begin
        cells[spot] = code[DATA_W-1:0];
        spot++;
      end
      if (spot < CELLS) begin
        cursor = spot;
      end else begin
        for (int unsigned i = 0; i < CELLS - COLS; i++) cells[i] = cells[i + COLS];
        wipe_row(ROWS - 1);
        cursor = (ROWS - 1) * COLS;
        r.scrolled = 1'b1;
      end
    end
    r.cursor_position = cursor[CURS_W-1:0];
    return r;
  endfunction

  initial begin
    fail_count = 0;
    backlog = 0;
    result_count = 0;
  end

  always @(posedge clk) begin : track
    cell_result_t got;
    cell_result_t want;
    if (!rst_n) begin
      for (int unsigned i = 0; i < CELLS; i++) cells[i] = '0;
      cursor = 0;
      awaited_results.delete();
    end else begin
      if (in_tap.valid && in_tap.ready)
        awaited_results.push_back(console_apply(in_tap.command, in_tap.char_code,
                                                in_tap.read_address));
      if (out_tap.valid && out_tap.ready) begin
        got = '{out_tap.read_data, out_tap.cursor_position, out_tap.scrolled};
        if (awaited_results.size() == 0) begin
          if (fail_count < 10)
            $display("monitor: result %0d arrived with nothing outstanding", result_count);
          fail_count = fail_count + 1;
        end else begin
          want = awaited_results.pop_front();
          if (got.read_data !== want.read_data ||
              got.cursor_position !== want.cursor_position ||
              got.scrolled !== want.scrolled) begin
            if (fail_count < 10)
              $display("monitor: result %0d read_data exp %0d got %0d, cursor exp %0d got %0d, scrolled exp %0d got %0d",
                       result_count, want.read_data, got.read_data,
                       want.cursor_position, got.cursor_position,
                       want.scrolled, got.scrolled);
            fail_count = fail_count + 1;
          end
        end
        result_count++;
      end
    end
    backlog <= awaited_results.size();
  end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import tccb_pkg::*;

  localparam int unsigned COLS  = 80;
  localparam int unsigned ROWS  = 25;
  localparam int unsigned CELLS = COLS * ROWS;
  localparam int unsigned ITEM_TARGET = 1300;
  // from here on neither side idles
  localparam int unsigned QUIET_FROM = 1150;
  localparam int unsigned LONG_HOLD  = 120;
  // a scroll walks every cell plus a row clear; leave room for one more after the last result
  localparam int unsigned DRAIN_CYCLES = CELLS + 4 * COLS;
  // worst case of this stimulus: ~1500 items all scrolling, with every gap and stall,
  // plus the clearing pass after reset; the limit sits roughly six times above that
  localparam int unsigned CYCLE_LIMIT = 20_000_000;

  logic        clk;
  logic        rst_n;
  int unsigned cycle_count = 0;
  int          fail_count;
  int          backlog;
  int unsigned useful_items = 0;
  int unsigned idle_pct = 0;
  bit          quiet_tail = 1'b0;
  bit          hold_long = 1'b0;

  tccb_in_if  in_ch ();
  tccb_out_if out_ch ();

  text_console_cell_buffer #(.COLS(COLS), .ROWS(ROWS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  cell_buffer_monitor #(.COLS(COLS), .ROWS(ROWS)) watch (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tap     (in_ch),
    .out_tap    (out_ch),
    .fail_count (fail_count),
    .backlog    (backlog)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // hang guard
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // result side: short random stalls, plus one long hold-off so the block backs up
  initial begin : receiver
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_long) begin
        hold_long = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (!quiet_tail && $urandom_range(0, 99) < idle_pct) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 2)) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // offer one item and hold it until taken; returns at the falling edge after the handshake
  task automatic send_item(input logic cmd, input logic [CODE_W-1:0] code,
                           input logic [ADDR_W-1:0] addr);
    if (!quiet_tail && $urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.command      <= cmd;
    in_ch.char_code    <= code;
    in_ch.read_address <= addr;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // ignored codes do not count toward the item target
    if (cmd == CMD_READ || code == CODE_BS || code == CODE_NL ||
        (code >= CODE_LO && code <= CODE_HI))
      useful_items++;
    @(negedge clk);
  endtask

  // put item: address field is don't-care, so fill it with noise
  task automatic put_char(input logic [CODE_W-1:0] code);
    send_item(CMD_PUT, code, ADDR_W'($urandom_range(0, 2 ** ADDR_W - 1)));
  endtask

  task automatic read_cell(input logic [ADDR_W-1:0] addr);
    send_item(CMD_READ, CODE_W'($urandom_range(0, 255)), addr);
  endtask

  // drop valid and wait until every result is back
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (backlog != 0);
  endtask

  initial begin : sender
    int unsigned pick;
    int unsigned run;
    int unsigned last_phase;
    bit          hold_done;
    bit          drain_done;
    logic [ADDR_W-1:0] addr;

    hold_done  = 1'b0;
    drain_done = 1'b0;
    last_phase = 0;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.command      <= CMD_PUT;
    in_ch.char_code    <= '0;
    in_ch.read_address <= '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: address extremes, including past the end of the store
    read_cell(ADDR_W'(0));
    read_cell(ADDR_W'(CELLS - 1));
    read_cell(ADDR_W'(CELLS));
    read_cell({ADDR_W{1'b1}});
    // printable range ends and an ordinary letter
    put_char(8'h41);
    put_char(CODE_LO);
    put_char(CODE_HI);
    // codes outside the printable range are dropped
    put_char(8'h00);
    put_char(8'h1F);
    put_char(8'h7F);
    put_char(8'hFF);
    read_cell(ADDR_W'(1));
    read_cell(ADDR_W'(2));
    // erase back to the origin, then backspace at cursor zero does nothing
    repeat (3) put_char(CODE_BS);
    put_char(CODE_BS);
    // newline then backspace across the row boundary clears the row it left
    put_char(8'h78);
    put_char(CODE_NL);
    put_char(CODE_BS);
    read_cell(ADDR_W'(COLS - 1));
    read_cell(ADDR_W'(0));
    settle();

    // random: mostly lines of text ending in newline, so the cursor reaches
    // the last row and scrolls; mixed with reads, erase runs and junk bytes
    while (useful_items < ITEM_TARGET) begin
      if (useful_items / 100 != last_phase) begin
        last_phase = useful_items / 100;
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 15;
          default: idle_pct = 40;
        endcase
      end
      quiet_tail = (useful_items >= QUIET_FROM);
      if (!hold_done && useful_items >= 400) begin
        hold_long = 1'b1;
        hold_done = 1'b1;
      end
      if (!drain_done && useful_items >= 700) begin
        settle();
        drain_done = 1'b1;
      end

      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        // a line; a few are long enough to wrap
        run = ($urandom_range(0, 99) < 15) ? $urandom_range(60, 100) : $urandom_range(0, 20);
        repeat (run) put_char(CODE_W'($urandom_range(CODE_LO, CODE_HI)));
        if ($urandom_range(0, 9) < 8) put_char(CODE_NL);
      end else if (pick < 70) begin
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(0, 9))
            0, 1, 2:    addr = ADDR_W'($urandom_range(0, 5 * COLS - 1));
            3, 4, 5, 6: addr = ADDR_W'($urandom_range((ROWS - 5) * COLS, CELLS - 1));
            7, 8:       addr = ADDR_W'($urandom_range(0, CELLS - 1));
            default:    addr = ADDR_W'($urandom_range(CELLS, 2 ** ADDR_W - 1));
          endcase
          read_cell(addr);
        end
      end else if (pick < 85) begin
        // erase run, sometimes long enough to climb back one or two rows
        run = ($urandom_range(0, 99) < 5) ? $urandom_range(20, 90) : $urandom_range(1, 5);
        repeat (run) put_char(CODE_BS);
      end else begin
        repeat ($urandom_range(1, 5)) put_char(CODE_W'($urandom_range(0, 255)));
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && backlog == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

@@ sim.f @@
sv/tccb_pkg.sv
sv/tccb_in_if.sv
sv/tccb_out_if.sv
sv/tccb_ram.sv
sv/text_console_cell_buffer.sv
bench/cell_buffer_monitor.sv
bench/testbench.sv
